// ===== rtl/core/ppp_pkg.sv =====
`default_nettype none
package ppp_pkg;

	// Fixed widths of the datapath
	localparam int DIFF_W = 33;   // point minus eye
	localparam int AXIS_W = 34;   // axis component, Q.30
	localparam int PROD_W = 67;   // offset times axis component
	localparam int DOT_W  = 37;   // dot product, Q16.16
	localparam int MAG_W  = 36;   // magnitude of a positive dot product
	localparam int EXT_W  = 84;   // frustum extent, Q.32
	localparam int QUO_W  = 28;   // quotient bits of the lateral ratio
	localparam int DIM_W  = 13;   // image dimension
	localparam int SUB_W  = 30;   // continuous coordinate before truncation

	// Configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HALF_TAN     = 2'd2;
	localparam logic [1:0] REG_ASPECT       = 2'd3;

	localparam logic signed [31:0] Q_LIM = 32'sh4000_0000;

	// d: point - eye; a: right (0..2), up (3..5), forward (6..8)
	typedef struct packed {
		logic [2:0][DIFF_W-1:0] d;
		logic [8:0][AXIS_W-1:0] a;
	} axes_t;

	typedef struct packed {
		logic [DOT_W-1:0] depth;
		logic [DOT_W-1:0] offx;
		logic [DOT_W-1:0] offy;
	} dot_t;

	typedef struct packed {
		logic [EXT_W-1:0] rem;
		logic [EXT_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             neg;
	} lane_t;

	typedef struct packed {
		logic        vis;
		logic [31:0] depth;
		lane_t       lx;
		lane_t       ly;
	} div_t;

	function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
		logic signed [31:0] r;
		priority if (v > Q_LIM) r = Q_LIM;
		else if (v < -Q_LIM) r = -Q_LIM;
		else r = v;
		return r;
	endfunction

	// One restoring step: shift the remainder in, subtract the divisor if it fits.
	function automatic lane_t div_step(input lane_t l);
		logic [EXT_W:0] t;
		logic [EXT_W:0] dd;
		lane_t r;
		r  = l;
		t  = {l.rem, 1'b0};
		dd = {1'b0, l.den};
		if (t >= dd) begin
			r.rem = EXT_W'(t - dd);
			r.quo = {l.quo[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = t[EXT_W-1:0];
			r.quo = {l.quo[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ppp_axes.sv =====
`default_nettype none
module ppp_axes (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [31:0]       point_x,
	input  logic [31:0]       point_y,
	input  logic [31:0]       point_z,
	input  logic [31:0]       eye_x,
	input  logic [31:0]       eye_y,
	input  logic [31:0]       eye_z,
	input  logic [31:0]       rot_w,
	input  logic [31:0]       rot_x,
	input  logic [31:0]       rot_y,
	input  logic [31:0]       rot_z,
	output logic              out_v,
	output ppp_pkg::axes_t    axes
);
	import ppp_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic [2:0][DIFF_W-1:0] d_s1, d_s2, d_s3;
	logic signed [31:0] qw_s1, qx_s1, qy_s1, qz_s1;
	// xx yy zz xy xz yz wx wy wz
	logic signed [63:0] pr_s2 [9];
	logic [8:0][AXIS_W-1:0] a_s3;
	logic signed [63:0] ax [9];

	localparam logic signed [63:0] ONE = 64'sh1000_0000_0000_0000;

	always_comb begin
		ax[0] = ONE - ((pr_s2[1] + pr_s2[2]) <<< 1);
		ax[1] = (pr_s2[3] + pr_s2[8]) <<< 1;
		ax[2] = (pr_s2[4] - pr_s2[7]) <<< 1;
		ax[3] = (pr_s2[3] - pr_s2[8]) <<< 1;
		ax[4] = ONE - ((pr_s2[0] + pr_s2[2]) <<< 1);
		ax[5] = (pr_s2[5] + pr_s2[6]) <<< 1;
		ax[6] = (pr_s2[4] + pr_s2[7]) <<< 1;
		ax[7] = (pr_s2[5] - pr_s2[6]) <<< 1;
		ax[8] = ONE - ((pr_s2[0] + pr_s2[1]) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DIFF_W'($signed(point_x)) - DIFF_W'($signed(eye_x));
			d_s1[1] <= DIFF_W'($signed(point_y)) - DIFF_W'($signed(eye_y));
			d_s1[2] <= DIFF_W'($signed(point_z)) - DIFF_W'($signed(eye_z));
			qw_s1   <= clamp_q($signed(rot_w));
			qx_s1   <= clamp_q($signed(rot_x));
			qy_s1   <= clamp_q($signed(rot_y));
			qz_s1   <= clamp_q($signed(rot_z));

			d_s2     <= d_s1;
			pr_s2[0] <= qx_s1 * qx_s1;
			pr_s2[1] <= qy_s1 * qy_s1;
			pr_s2[2] <= qz_s1 * qz_s1;
			pr_s2[3] <= qx_s1 * qy_s1;
			pr_s2[4] <= qx_s1 * qz_s1;
			pr_s2[5] <= qy_s1 * qz_s1;
			pr_s2[6] <= qw_s1 * qx_s1;
			pr_s2[7] <= qw_s1 * qy_s1;
			pr_s2[8] <= qw_s1 * qz_s1;

			d_s3 <= d_s2;
			for (int k = 0; k < 9; k++) a_s3[k] <= ax[k][63:30];
		end
	end

	assign out_v  = v_s3;
	assign axes.d = d_s3;
	assign axes.a = a_s3;
endmodule
`default_nettype wire

// ===== rtl/core/ppp_dot.sv =====
`default_nettype none
module ppp_dot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  ppp_pkg::axes_t axes,
	output logic           out_v,
	output ppp_pkg::dot_t  dot
);
	import ppp_pkg::*;

	logic v_s4, v_s5;
	logic signed [PROD_W-1:0] pr_s4 [9];
	logic [2:0][DOT_W-1:0] dot_s5;
	logic signed [PROD_W+1:0] sum [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			sum[k] = (PROD_W+2)'(pr_s4[k*3]) + (PROD_W+2)'(pr_s4[k*3+1])
				+ (PROD_W+2)'(pr_s4[k*3+2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					pr_s4[k*3+j] <= $signed(axes.d[j]) * $signed(axes.a[k*3+j]);
			// floor by 2^30; the true value fits the dot width
			for (int k = 0; k < 3; k++) dot_s5[k] <= sum[k][DOT_W+29:30];
		end
	end

	assign out_v     = v_s5;
	assign dot.offx  = dot_s5[0];
	assign dot.offy  = dot_s5[1];
	assign dot.depth = dot_s5[2];
endmodule
`default_nettype wire

// ===== rtl/core/ppp_extent.sv =====
`default_nettype none
module ppp_extent (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  ppp_pkg::dot_t             dot,
	input  logic [31:0]               half_tan,
	input  logic [63:0]               tx,
	input  logic [ppp_pkg::DIM_W-1:0] dim_w,
	input  logic [ppp_pkg::DIM_W-1:0] dim_h,
	output logic                      out_v,
	output ppp_pkg::div_t             dv
);
	import ppp_pkg::*;

	logic v_s6, v_s7, v_s8;
	logic ok_s6, ok_s7;
	logic [31:0] dep_s6, dep_s7;
	logic [67:0] pxl_s6, pxh_s6, py_s6;
	logic [MAG_W-1:0] absx_s6, absy_s6, absx_s7, absy_s7;
	logic negx_s6, negy_s6, negx_s7, negy_s7;
	logic [EXT_W-1:0] ex_s7, ey_s7;
	logic [DIM_W+MAG_W-1:0] mx_s7, my_s7;
	div_t dv_s8;

	logic pos;
	logic [MAG_W-1:0] dpos;
	logic [DOT_W-1:0] nx, ny;
	logic [99:0] full;
	logic fitx, fity;

	always_comb begin
		pos  = !dot.depth[DOT_W-1] && (dot.depth != '0);
		dpos = pos ? dot.depth[MAG_W-1:0] : '0;
		nx   = -dot.offx;
		ny   = -dot.offy;
		full = {pxh_s6, 32'b0} + {32'b0, pxl_s6};
		fitx = (ex_s7 != '0) && ({32'b0, absx_s7, 16'b0} <= ex_s7);
		fity = (ey_s7 != '0) && ({32'b0, absy_s7, 16'b0} <= ey_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= in_v;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s6   <= pos && (half_tan != '0) && (tx != '0);
			dep_s6  <= (dpos > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : dpos[31:0];
			pxl_s6  <= dpos * tx[31:0];
			pxh_s6  <= dpos * tx[63:32];
			py_s6   <= dpos * half_tan;
			negx_s6 <= dot.offx[DOT_W-1];
			negy_s6 <= dot.offy[DOT_W-1];
			absx_s6 <= dot.offx[DOT_W-1] ? nx[MAG_W-1:0] : dot.offx[MAG_W-1:0];
			absy_s6 <= dot.offy[DOT_W-1] ? ny[MAG_W-1:0] : dot.offy[MAG_W-1:0];

			ok_s7   <= ok_s6;
			dep_s7  <= dep_s6;
			ex_s7   <= full[99:16];
			ey_s7   <= {16'b0, py_s6};
			mx_s7   <= dim_w * absx_s6;
			my_s7   <= dim_h * absy_s6;
			absx_s7 <= absx_s6;
			absy_s7 <= absy_s6;
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;

			dv_s8.vis    <= ok_s7 && fitx && fity;
			dv_s8.depth  <= dep_s7;
			dv_s8.lx.rem <= {32'b0, mx_s7, 3'b0};
			dv_s8.lx.den <= ex_s7;
			dv_s8.lx.quo <= '0;
			dv_s8.lx.neg <= negx_s7;
			dv_s8.ly.rem <= {32'b0, my_s7, 3'b0};
			dv_s8.ly.den <= ey_s7;
			dv_s8.ly.quo <= '0;
			dv_s8.ly.neg <= negy_s7;
		end
	end

	assign out_v = v_s8;
	assign dv    = dv_s8;
endmodule
`default_nettype wire

// ===== rtl/core/ppp_divider.sv =====
`default_nettype none
module ppp_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  ppp_pkg::div_t din,
	output logic          out_v,
	output ppp_pkg::div_t dout
);
	import ppp_pkg::*;

	div_t div_sn [QUO_W];
	logic v_sn [QUO_W];
	div_t nx [QUO_W];

	always_comb begin
		for (int i = 0; i < QUO_W; i++) begin
			nx[i]    = (i == 0) ? din : div_sn[(i == 0) ? 0 : i-1];
			nx[i].lx = div_step(nx[i].lx);
			nx[i].ly = div_step(nx[i].ly);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) v_sn[i] <= 1'b0;
		end else if (en) begin
			v_sn[0] <= in_v;
			for (int i = 1; i < QUO_W; i++) v_sn[i] <= v_sn[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) div_sn[i] <= nx[i];
		end
	end

	assign out_v = v_sn[QUO_W-1];
	assign dout  = div_sn[QUO_W-1];
endmodule
`default_nettype wire

// ===== rtl/core/perspective_point_to_pixel_top.sv =====
`default_nettype none
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------
// input     | in_valid / in_stall   | point_x..z, eye_x..z, rot_w..z
// output    | out_valid / out_stall | visible, pixel_x/y, sub_x/y, depth
// config    | cfg_wen               | cfg_index, cfg_data
//
// One transaction is taken every cycle while the output is not held; each
// result passes through the 28 one-bit steps of the divider lanes plus 10
// arithmetic stages.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
// A held output stalls the whole pipeline in place; in_stall mirrors it.
module perspective_point_to_pixel_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] eye_x,
	input  logic [31:0] eye_y,
	input  logic [31:0] eye_z,
	input  logic [31:0] rot_w,
	input  logic [31:0] rot_x,
	input  logic [31:0] rot_y,
	input  logic [31:0] rot_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        visible,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [28:0] sub_x,
	output logic [28:0] sub_y,
	output logic [31:0] depth,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ppp_pkg::*;

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [31:0] tan_q, aspect_q;
	// horizontal extent factor, aspect * tangent (Q32.32); settles in the cycle after
	// a write, long before any transaction reaches the extent stage
	logic [63:0] tx_q;

	logic en;
	logic v_ax, v_dot, v_ext, v_div;
	axes_t axes;
	dot_t  dot;
	div_t  dv_ext, dv_div;

	logic [DIM_W-1:0] dim_w, dim_h;

	// final two stages: coordinate assembly, then rounding and clamping
	logic v_s37, vis_s37;
	logic [31:0] dep_s37;
	logic [SUB_W-1:0] sx_s37, sy_s37;
	logic v_s38, vis_s38;
	logic [11:0] px_s38, py_s38;
	logic [28:0] sx_s38, sy_s38;
	logic [31:0] dep_s38;

	logic [SUB_W-1:0] rx, ry;
	logic [DIM_W-1:0] pxr, pyr;

	// zero acts as one, anything above the limit acts as the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		priority if (r == '0) d = DIM_W'(1);
		else if (32'(r) > 32'(MAX_DIM)) d = DIM_W'(MAX_DIM);
		else d = r;
		return d;
	endfunction

	// sub = dim * 2^15 + floor(+-q); a negative side rounds the magnitude up
	function automatic logic [SUB_W-1:0] sub_coord(input lane_t l,
			input logic [DIM_W-1:0] dim);
		logic [SUB_W-1:0] base, mag;
		base = {2'b0, dim, 15'b0};
		mag  = {2'b0, l.quo} + SUB_W'(l.rem != '0);
		return l.neg ? (base - mag) : (base + {2'b0, l.quo});
	endfunction

	function automatic logic [DIM_W-1:0] round_pix(input logic [SUB_W-1:0] s,
			input logic [DIM_W-1:0] dim);
		logic [SUB_W-1:0] t;
		logic [DIM_W-1:0] p, lim;
		t   = s + SUB_W'(32768);
		p   = t[DIM_W+15:16];
		lim = dim - DIM_W'(1);
		return (p > lim) ? lim : p;
	endfunction

	assign dim_w = eff_dim(width_q);
	assign dim_h = eff_dim(height_q);

	// whole pipeline advances unless a finished result is being held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			tan_q    <= 32'h0001_0000;
			aspect_q <= 32'h0001_0000;
			tx_q     <= 64'h1_0000_0000;
		end else begin
			tx_q <= aspect_q * tan_q;
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					REG_HALF_TAN:     tan_q    <= cfg_data;
					REG_ASPECT:       aspect_q <= cfg_data;
				endcase
			end
		end
	end

	// stages 1-3: eye offset, quaternion products, camera axes
	ppp_axes u_axes (
		.clk, .arst_n, .en, .in_v(in_valid),
		.point_x, .point_y, .point_z, .eye_x, .eye_y, .eye_z,
		.rot_w, .rot_x, .rot_y, .rot_z,
		.out_v(v_ax), .axes
	);

	// stages 4-5: depth and lateral offsets
	ppp_dot u_dot (
		.clk, .arst_n, .en, .in_v(v_ax), .axes, .out_v(v_dot), .dot
	);

	// stages 6-8: frustum extents, visibility, divider set-up
	ppp_extent u_ext (
		.clk, .arst_n, .en, .in_v(v_dot), .dot,
		.half_tan(tan_q), .tx(tx_q), .dim_w, .dim_h,
		.out_v(v_ext), .dv(dv_ext)
	);

	// stages 9-36: offset-to-extent ratio, both axes side by side
	ppp_divider u_div (
		.clk, .arst_n, .en, .in_v(v_ext), .din(dv_ext), .out_v(v_div), .dout(dv_div)
	);

	always_comb begin
		rx  = sub_coord(dv_div.lx, dim_w);
		ry  = sub_coord(dv_div.ly, dim_h);
		pxr = round_pix(sx_s37, dim_w);
		pyr = round_pix(sy_s37, dim_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
		end else if (en) begin
			v_s37 <= v_div;
			v_s38 <= v_s37;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s37 <= dv_div.vis;
			dep_s37 <= dv_div.depth;
			sx_s37  <= rx;
			sy_s37  <= ry;

			// an invisible point reports all fields as zero
			vis_s38 <= vis_s37;
			px_s38  <= vis_s37 ? pxr[11:0] : '0;
			py_s38  <= vis_s37 ? pyr[11:0] : '0;
			sx_s38  <= vis_s37 ? sx_s37[28:0] : '0;
			sy_s38  <= vis_s37 ? sy_s37[28:0] : '0;
			dep_s38 <= vis_s37 ? dep_s37 : '0;
		end
	end

	assign out_valid = v_s38;
	assign visible   = vis_s38;
	assign pixel_x   = px_s38;
	assign pixel_y   = py_s38;
	assign sub_x     = sx_s38;
	assign sub_y     = sy_s38;
	assign depth     = dep_s38;
endmodule
`default_nettype wire

// ===== rtl/core/ppp_checker.sv =====
`default_nettype none
module ppp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        visible,
	input logic [11:0] pixel_x,
	input logic [11:0] pixel_y,
	input logic [28:0] sub_x,
	input logic [28:0] sub_y,
	input logic [31:0] depth
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(sub_x)
			&& $stable(depth) && $stable(visible))
		else $error("held result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> pixel_x == 12'd0 && pixel_y == 12'd0
			&& sub_x == 29'd0 && sub_y == 29'd0 && depth == 32'd0)
		else $error("hidden point with nonzero fields");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> depth != 32'd0)
		else $error("visible point with zero depth");

	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> {17'd0, pixel_x} <= ((sub_x + 29'd32768) >> 16)
			&& {17'd0, pixel_y} <= ((sub_y + 29'd32768) >> 16))
		else $error("pixel above rounded coordinate");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
endmodule

bind perspective_point_to_pixel_top ppp_checker u_chk (.*);
`default_nettype wire
